/* rtl/core/axsm_pkg.sv */
package axsm_pkg;

    localparam int SD_DEPTH  = 256;
    localparam int DATA_W    = 32;
    localparam int PTR_W     = $clog2(SD_DEPTH);
    localparam int CNT_W     = $clog2(SD_DEPTH + 1);
    localparam int WAIT_W    = 16;
    localparam int IN_BITS   = 102;
    localparam int OUT_BITS  = 102;
    localparam int IN_BYTES  = (IN_BITS + 7) / 8;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
    localparam int IN_PAD    = IN_BYTES * 8 - IN_BITS;
    localparam int OUT_PAD   = OUT_BYTES * 8 - OUT_BITS;

    localparam logic [WAIT_W-1:0] WAIT_RESET = WAIT_W'(100);

    // command selector carried in tuser
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // input request, last field in the lowest bits
    typedef struct packed {
        logic [IN_PAD-1:0] pad;
        logic              bvalid;
        logic              wready;
        logic              awready;
        logic [DATA_W-1:0] rdata;
        logic              rvalid;
        logic              arready;
        logic [DATA_W-1:0] entry_value;
        logic [DATA_W-1:0] entry_address;
        logic              entry_is_read;
    } in_item_t;

    // result, last field in the lowest bits
    typedef struct packed {
        logic [OUT_PAD-1:0] pad;
        logic               finished;
        logic               bready;
        logic [DATA_W-1:0]  write_data;
        logic               wvalid;
        logic [DATA_W-1:0]  write_address;
        logic               awvalid;
        logic               rready;
        logic [DATA_W-1:0]  read_address;
        logic               arvalid;
    } out_item_t;

    // one script entry as stored
    typedef struct packed {
        logic              is_read;
        logic [DATA_W-1:0] address;
        logic [DATA_W-1:0] value;
    } entry_t;

endpackage

/* rtl/core/axi_lite_script_master_core.sv */
// Append request: written straight into the script memory when taken.
// Tick request: the script memory read of the front entry is registered first,
// then the bus phase steps and the output register loads once it is free or
// being drained; no new request is taken until the tick has finished.
// Reset (aresetn low, synchronous): phase idle, counters, pointers and the
// finished flag cleared, idle wait back to 100. Script memory is not cleared.
module axi_lite_script_master_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tdata, low bit up: entry_is_read, entry_address, entry_value, arready,
    // rvalid, rdata, awready, wready, bvalid, zero fill
    input  logic [axsm_pkg::IN_BYTES*8-1:0]      s_tdata,
    // tuser: command (0 append, 1 tick)
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // tdata, low bit up: arvalid, read_address, rready, awvalid,
    // write_address, wvalid, write_data, bready, finished, zero fill
    output logic [axsm_pkg::OUT_BYTES*8-1:0]     m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [axsm_pkg::WAIT_W-1:0]          cfg_data
);
    import axsm_pkg::*;

    // bus phase of the script engine
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_RADDR = 3'd1,
        PH_RDATA = 3'd2,
        PH_WADDR = 3'd3,
        PH_WDATA = 3'd4,
        PH_WRESP = 3'd5
    } phase_t;

    // request sequencing: take a request, or finish a tick after the memory read
    typedef enum logic {
        ST_TAKE,
        ST_EXEC
    } seq_t;

    seq_t               seq_reg;
    phase_t             phase_reg, phase_next;
    logic [WAIT_W-1:0]  idle_count_reg, idle_count_next;
    logic [WAIT_W-1:0]  idle_wait_reg;
    logic               done_reg, done_next;
    logic [PTR_W-1:0]   head_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               m_valid_reg;
    out_item_t          out_reg, out_next;
    in_item_t           tick_reg;
    entry_t             front_reg;

    // script memory: one write port (append), one registered read port (front)
    entry_t             script_mem [SD_DEPTH];

    in_item_t           in_item;
    logic               take;
    logic               take_append;
    logic               take_tick;
    logic               store_full;
    logic               advance;
    logic               pop;
    logic [WAIT_W-1:0]  idle_inc;
    logic [PTR_W:0]     slot_sum;
    logic [PTR_W-1:0]   tail_slot;
    logic [PTR_W-1:0]   head_inc;
    entry_t             new_entry;

    assign in_item     = in_item_t'(s_tdata);
    assign s_tready    = (seq_reg == ST_TAKE);
    assign take        = s_tvalid && s_tready;
    assign take_append = take && (s_tuser == CMD_APPEND);
    assign take_tick   = take && (s_tuser == CMD_TICK);
    assign store_full  = (count_reg == CNT_W'(SD_DEPTH));

    // finish a tick only when the output register is free or being drained
    assign advance     = (seq_reg == ST_EXEC) && (!m_valid_reg || m_tready);

    assign cfg_ready   = 1'b1;
    assign m_tvalid    = m_valid_reg;
    assign m_tdata     = out_reg;

    // tail slot = head + count, wrapped at the script depth
    assign slot_sum  = (PTR_W+1)'(head_reg) + (PTR_W+1)'(count_reg);
    assign tail_slot = (slot_sum >= (PTR_W+1)'(SD_DEPTH)) ?
                       PTR_W'(slot_sum - (PTR_W+1)'(SD_DEPTH)) : PTR_W'(slot_sum);
    assign head_inc  = (head_reg == PTR_W'(SD_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    assign new_entry.is_read = in_item.entry_is_read;
    assign new_entry.address = in_item.entry_address;
    assign new_entry.value   = in_item.entry_value;

    assign idle_inc = idle_count_reg + 1'b1;

    // step the bus phase using the front entry read when the tick was taken
    always_comb begin
        phase_next      = phase_reg;
        idle_count_next = idle_count_reg;
        done_next       = done_reg;
        pop             = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                idle_count_next = idle_inc;
                if (idle_inc >= idle_wait_reg) begin
                    idle_count_next = '0;
                    if (count_reg == '0) begin
                        done_next = 1'b1;
                    end else begin
                        phase_next = front_reg.is_read ? PH_RADDR : PH_WADDR;
                    end
                end
            end
            PH_RADDR: begin
                if (tick_reg.arready) phase_next = PH_RDATA;
            end
            PH_RDATA: begin
                if (tick_reg.rvalid) begin
                    phase_next      = PH_IDLE;
                    idle_count_next = '0;
                    // pop only on a match; a mismatch re-polls after the wait
                    pop = (count_reg != '0) && (front_reg.value == tick_reg.rdata);
                end
            end
            PH_WADDR: begin
                if (tick_reg.awready) phase_next = PH_WDATA;
            end
            PH_WDATA: begin
                if (tick_reg.wready) phase_next = PH_WRESP;
            end
            PH_WRESP: begin
                if (tick_reg.bvalid) begin
                    phase_next      = PH_IDLE;
                    idle_count_next = '0;
                    pop             = (count_reg != '0);
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        // a pop always lands in idle, so the fields below never need the new front
        out_next               = '0;
        out_next.arvalid       = (phase_next == PH_RADDR);
        out_next.read_address  = (phase_next == PH_RADDR) ? front_reg.address : '0;
        out_next.rready        = (phase_next == PH_RDATA);
        out_next.awvalid       = (phase_next == PH_WADDR);
        out_next.write_address = (phase_next == PH_WADDR) ? front_reg.address : '0;
        out_next.wvalid        = (phase_next == PH_WDATA);
        out_next.write_data    = (phase_next == PH_WDATA) ? front_reg.value : '0;
        out_next.bready        = (phase_next == PH_WRESP);
        out_next.finished      = done_next;
    end

    // control state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg        <= ST_TAKE;
            phase_reg      <= PH_IDLE;
            idle_count_reg <= '0;
            idle_wait_reg  <= WAIT_RESET;
            done_reg       <= 1'b0;
            head_reg       <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                idle_wait_reg <= cfg_data;
            end
            // load a finished tick, else drop valid once the result is taken
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (seq_reg)
                ST_TAKE: begin
                    // append to a full store: drop it
                    if (take_append && !store_full) begin
                        count_reg <= count_reg + 1'b1;
                    end
                    if (take_tick) begin
                        seq_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (advance) begin
                        phase_reg      <= phase_next;
                        idle_count_reg <= idle_count_next;
                        done_reg       <= done_next;
                        seq_reg        <= ST_TAKE;
                        if (pop) begin
                            head_reg  <= head_inc;
                            count_reg <= count_reg - 1'b1;
                        end
                    end
                end
                default: begin
                    seq_reg <= ST_TAKE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (take_tick) begin
            tick_reg <= in_item;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    // script memory: write the tail on append, read the front on tick
    always_ff @(posedge aclk) begin
        if (take_append && !store_full) begin
            script_mem[tail_slot] <= new_entry;
        end
        if (take_tick) begin
            front_reg <= script_mem[head_reg];
        end
    end

    // fill count never passes the script depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SD_DEPTH))
        else $error("script fill count above depth");

    // finished is sticky until reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(done_reg))
        else $error("finished flag dropped");

    // an active bus phase always has a front entry behind it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_IDLE) |-> (count_reg != '0))
        else $error("bus phase active with empty script");

    // append to a full store leaves the fill count unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take_append && store_full) |=> (count_reg == CNT_W'(SD_DEPTH)))
        else $error("append to full script changed fill count");

endmodule
